// ===== src/tacs_pkg.sv =====
// Shared types and constants for the touch averaging / calibration block.
// No dependencies; imported by touch_average_clip_scale and its testbench.
package tacs_pkg;

  localparam int RAW_W      = 16;
  localparam int SPAN_W     = 10;
  localparam int EV_W       = 2;
  localparam int PROD_W     = RAW_W + SPAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y    = 3'd6;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_BEGIN = 2'd1;
  localparam logic [EV_W-1:0] EV_END   = 2'd2;

  typedef struct packed {
    logic             pen_down;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } tacs_in_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic              pressed;
    logic [SPAN_W-1:0] screen_x;
    logic [SPAN_W-1:0] screen_y;
  } tacs_out_t;

endpackage

// ===== src/touch_average_clip_scale.sv =====
// Touch sample averaging, clipping and inverse linear scaling, top level.
// Depends on tacs_pkg (types, register indexes, event codes).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_valid / in_ready  | tacs_in_t  : pen_down, raw_x, raw_y
//  out_    | out | out_valid / out_ready| tacs_out_t : event_res, pressed, x, y
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata (16 bit)
//
// A pen-down request that does not complete an acquisition is only added to
// the running sums. A completing request is accepted, then per axis goes
// through one bit-serial restoring divide for the average, a clip, a bit-serial
// multiply by span and a second divide, both divides on the single shared
// divider (a collapsed or reversed range gives zero), then into the output
// register. A pen-up request is accepted and its report loaded into the
// output register. Reset is synchronous, active low. A finished result sits
// in the output register while the next request is taken; the block stalls
// the input while it computes and while a new result waits for that register.

module touch_average_clip_scale #(
  parameter int SAMPLES_AVERAGED = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tacs_pkg::tacs_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tacs_pkg::tacs_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [tacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tacs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tacs_pkg::*;

  // accumulator and divider sizing
  localparam int CNT_W     = $clog2(SAMPLES_AVERAGED + 1);
  localparam int SUM_W     = RAW_W + $clog2(SAMPLES_AVERAGED);
  localparam int DIV_W     = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [CNT_W-1:0]     NEED_AVG = CNT_W'(SAMPLES_AVERAGED);
  localparam logic [CNT_W-1:0]     NEED_ONE = CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
  localparam logic [DIV_CNT_W-1:0] MUL_LAST = DIV_CNT_W'(SPAN_W - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;  // sum / sample count
  localparam logic [2:0] S_MAP  = 3'd2;  // clip, offset, range
  localparam logic [2:0] S_MUL  = 3'd3;  // offset * span, one span bit a cycle
  localparam logic [2:0] S_DIV  = 3'd4;  // product / range
  localparam logic [2:0] S_PUSH = 3'd5;  // hand result to output register

  // configuration
  logic              normalize_r;
  logic [RAW_W-1:0]  min_x_r, max_x_r, min_y_r, max_y_r;
  logic [SPAN_W-1:0] span_x_r, span_y_r;

  // block state
  logic [2:0]        state_r, state_nxt;
  logic              press_r, press_nxt;
  logic [SPAN_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [SUM_W-1:0]  sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ax_r, ax_nxt;     // 0 x axis, 1 y axis
  logic [SPAN_W-1:0] res_x_r, res_x_nxt;

  // shared serial datapath
  logic [DIV_W-1:0]     div_q_r, div_q_nxt;
  logic [RAW_W-1:0]     div_rem_r, div_rem_nxt;
  logic [RAW_W-1:0]     div_den_r, div_den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0]     mul_a_r, mul_a_nxt;
  logic [SPAN_W-1:0]    mul_b_r, mul_b_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  // result staging and output register
  tacs_out_t pend_r, pend_nxt;
  tacs_out_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // divider step
  logic [RAW_W:0]    rem_sh, rem_sub;
  logic              rem_ge;
  logic [RAW_W-1:0]  rem_step;
  logic [DIV_W-1:0]  q_step;

  // comb helpers
  logic              in_fire;
  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  count_inc;
  logic [SUM_W-1:0]  sum_x_add, sum_y_add;
  logic [RAW_W-1:0]  lo, hi, avg, vclip;
  logic [SPAN_W-1:0] span;
  logic              axis_done;
  logic [SPAN_W-1:0] axis_val;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign need      = normalize_r ? NEED_AVG : NEED_ONE;
  assign count_inc = count_r + CNT_W'(1);
  assign sum_x_add = sum_x_r + SUM_W'(in_data.raw_x);
  assign sum_y_add = sum_y_r + SUM_W'(in_data.raw_y);

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {div_rem_r, div_q_r[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_den_r};
  assign rem_ge   = (rem_sh >= {1'b0, div_den_r});
  assign rem_step = rem_ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
  assign q_step   = {div_q_r[DIV_W-2:0], rem_ge};

  assign lo    = ax_r ? min_y_r  : min_x_r;
  assign hi    = ax_r ? max_y_r  : max_x_r;
  assign span  = ax_r ? span_y_r : span_x_r;
  assign avg   = div_q_r[RAW_W-1:0];
  assign vclip = (avg < lo) ? lo : ((avg > hi) ? hi : avg);

  always_comb begin
    state_nxt     = state_r;
    press_nxt     = press_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    count_nxt     = count_r;
    ax_nxt        = ax_r;
    res_x_nxt     = res_x_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_den_nxt   = div_den_r;
    cnt_nxt       = cnt_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    prod_nxt      = prod_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    axis_done     = 1'b0;
    axis_val      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_data.pen_down) begin
            // pen up: end any press, report last coordinate
            sum_x_nxt          = '0;
            sum_y_nxt          = '0;
            count_nxt          = '0;
            press_nxt          = 1'b0;
            pend_nxt.event_res = press_r ? EV_END : EV_NONE;
            pend_nxt.pressed   = 1'b0;
            pend_nxt.screen_x  = last_x_r;
            pend_nxt.screen_y  = last_y_r;
            state_nxt          = S_PUSH;
          end else begin
            sum_x_nxt = sum_x_add;
            sum_y_nxt = sum_y_add;
            count_nxt = count_inc;
            if (count_inc >= need) begin
              ax_nxt      = 1'b0;
              div_q_nxt   = DIV_W'(sum_x_add);
              div_rem_nxt = '0;
              div_den_nxt = RAW_W'(need);
              cnt_nxt     = '0;
              state_nxt   = S_AVG;
            end
          end
        end
      end
      S_AVG: begin
        div_q_nxt   = q_step;
        div_rem_nxt = rem_step;
        cnt_nxt     = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (hi <= lo) begin
          // degenerate or reversed calibration: axis reads zero
          axis_done = 1'b1;
          axis_val  = '0;
        end else begin
          mul_a_nxt   = vclip - lo;
          mul_b_nxt   = span;
          prod_nxt    = '0;
          div_den_nxt = hi - lo;
          cnt_nxt     = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {prod_r[PROD_W-2:0], 1'b0} +
                    (mul_b_r[SPAN_W-1] ? PROD_W'(mul_a_r) : PROD_W'(0));
        mul_b_nxt = {mul_b_r[SPAN_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          div_q_nxt   = DIV_W'(prod_nxt);
          div_rem_nxt = '0;
          cnt_nxt     = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        div_q_nxt   = q_step;
        div_rem_nxt = rem_step;
        cnt_nxt     = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          // quotient never exceeds span, so the low bits suffice
          axis_done = 1'b1;
          axis_val  = span - q_step[SPAN_W-1:0];
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (axis_done) begin
      if (!ax_r) begin
        res_x_nxt   = axis_val;
        ax_nxt      = 1'b1;
        div_q_nxt   = DIV_W'(sum_y_r);
        div_rem_nxt = '0;
        div_den_nxt = RAW_W'(need);
        cnt_nxt     = '0;
        state_nxt   = S_AVG;
      end else begin
        pend_nxt.event_res = press_r ? EV_NONE : EV_BEGIN;
        pend_nxt.pressed   = 1'b1;
        pend_nxt.screen_x  = res_x_r;
        pend_nxt.screen_y  = axis_val;
        press_nxt          = 1'b1;
        last_x_nxt         = res_x_r;
        last_y_nxt         = axis_val;
        sum_x_nxt          = '0;
        sum_y_nxt          = '0;
        count_nxt          = '0;
        state_nxt          = S_PUSH;
      end
    end

    // mode change restarts accumulation; writes must come only while idle, which is left to the user to ensure
    if (cfg_we && (cfg_index == REG_NORMALIZE)) begin
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      count_nxt = '0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      press_r     <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      count_r     <= '0;
      ax_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      press_r     <= press_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      count_r     <= count_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normalize_r <= 1'b1;
      min_x_r     <= RAW_W'(0);
      max_x_r     <= RAW_W'(4095);
      min_y_r     <= RAW_W'(0);
      max_y_r     <= RAW_W'(4095);
      span_x_r    <= SPAN_W'(240);
      span_y_r    <= SPAN_W'(320);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMALIZE: normalize_r <= cfg_wdata[0];
        REG_MIN_X:     min_x_r     <= cfg_wdata[RAW_W-1:0];
        REG_MAX_X:     max_x_r     <= cfg_wdata[RAW_W-1:0];
        REG_MIN_Y:     min_y_r     <= cfg_wdata[RAW_W-1:0];
        REG_MAX_Y:     max_y_r     <= cfg_wdata[RAW_W-1:0];
        REG_SPAN_X:    span_x_r    <= cfg_wdata[SPAN_W-1:0];
        REG_SPAN_Y:    span_y_r    <= cfg_wdata[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    res_x_r   <= res_x_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    cnt_r     <= cnt_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    prod_r    <= prod_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== test/touch_average_clip_scale_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for touch_average_clip_scale: directed and random touch strokes.
// Depends on tacs_pkg and touch_average_clip_scale; predicts each report in-line.
module touch_average_clip_scale_test;
  import tacs_pkg::*;

  // Block build and derived widths of the accumulators.
  localparam int SAMPLES = 16;
  localparam int ACC_W   = RAW_W + $clog2(SAMPLES);
  localparam int CNT_W   = $clog2(SAMPLES + 1);

  // Wait past any completing request before a register write so that nothing
  // is still in flight.
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 85;

  // Calibration registers as the predictor sees them.
  typedef struct packed {
    logic              mode;
    logic [RAW_W-1:0]  min_x;
    logic [RAW_W-1:0]  max_x;
    logic [RAW_W-1:0]  min_y;
    logic [RAW_W-1:0]  max_y;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;
  } calib_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  tacs_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tacs_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state: registers, press tracking, running sums.
  calib_t            calib;
  logic              pen_held;
  logic [SPAN_W-1:0] last_sx, last_sy;
  logic [ACC_W-1:0]  acc_x, acc_y;
  logic [CNT_W-1:0]  acc_n;

  tacs_out_t touch_reports_due[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        stall_left  = 0;
  bit        idle_on     = 1'b0;
  bit        stalls_on   = 1'b0;

  touch_average_clip_scale #(
    .SAMPLES_AVERAGED (SAMPLES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_sums();
    acc_x = '0;
    acc_y = '0;
    acc_n = '0;
  endfunction

  function automatic void reset_predictor();
    calib.mode   = 1'b1;
    calib.min_x  = 16'd0;
    calib.max_x  = 16'd4095;
    calib.min_y  = 16'd0;
    calib.max_y  = 16'd4095;
    calib.span_x = 10'd240;
    calib.span_y = 10'd320;
    pen_held     = 1'b0;
    last_sx      = '0;
    last_sy      = '0;
    clear_sums();
  endfunction

  // Clip to [lo, hi], then map inversely: span at lo down to 0 at hi.
  // A collapsed or reversed range maps everything to 0.
  function automatic logic [SPAN_W-1:0] scale_axis(input logic [RAW_W-1:0] v,
                                                   input logic [RAW_W-1:0] lo,
                                                   input logic [RAW_W-1:0] hi,
                                                   input logic [SPAN_W-1:0] span);
    logic [PROD_W-1:0] prod;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (hi <= lo) return '0;
    prod = PROD_W'(v - lo) * PROD_W'(span);
    return SPAN_W'(PROD_W'(span) - prod / PROD_W'(hi - lo));
  endfunction

  // Works out the report (if any) that one accepted request causes.
  function automatic void track_touch(input tacs_in_t s);
    tacs_out_t        r;
    logic [CNT_W-1:0] need;
    logic [RAW_W-1:0] avg_x, avg_y;
    need = calib.mode ? CNT_W'(SAMPLES) : CNT_W'(1);
    if (!s.pen_down) begin
      // Pen lifted: drop the partial average, report last position.
      clear_sums();
      r.event_res = pen_held ? EV_END : EV_NONE;
      r.pressed   = 1'b0;
      r.screen_x  = last_sx;
      r.screen_y  = last_sy;
      pen_held    = 1'b0;
      touch_reports_due.push_back(r);
      return;
    end
    acc_x = acc_x + ACC_W'(s.raw_x);
    acc_y = acc_y + ACC_W'(s.raw_y);
    acc_n = acc_n + CNT_W'(1);
    if (acc_n < need) return;
    avg_x = RAW_W'(acc_x / ACC_W'(need));
    avg_y = RAW_W'(acc_y / ACC_W'(need));
    last_sx = scale_axis(avg_x, calib.min_x, calib.max_x, calib.span_x);
    last_sy = scale_axis(avg_y, calib.min_y, calib.max_y, calib.span_y);
    clear_sums();
    r.event_res = pen_held ? EV_NONE : EV_BEGIN;
    r.pressed   = 1'b1;
    r.screen_x  = last_sx;
    r.screen_y  = last_sy;
    pen_held    = 1'b1;
    touch_reports_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Every accepted report is matched against the oldest prediction.
  always @(posedge clk) begin : check_reports
    tacs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (touch_reports_due.size() == 0) begin
        report_mismatch("report with none pending", int'(out_data), 0);
      end else begin
        want = touch_reports_due.pop_front();
        if (out_data.event_res != want.event_res)
          report_mismatch("event_res", out_data.event_res, want.event_res);
        if (out_data.pressed != want.pressed)
          report_mismatch("pressed", out_data.pressed, want.pressed);
        if (out_data.screen_x != want.screen_x)
          report_mismatch("screen_x", out_data.screen_x, want.screen_x);
        if (out_data.screen_y != want.screen_y)
          report_mismatch("screen_y", out_data.screen_y, want.screen_y);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Receiver side back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready = 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Offer one request; returns at the rising edge where it is taken. Valid
  // stays high after that until the next negedge, where either new data goes
  // out or valid drops for a gap.
  task automatic send_touch(input tacs_in_t s);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = s;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_touch(s);
  endtask

  // Let every pending report drain and the datapath go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (touch_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the predictor takes the same value at the same edge.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      REG_NORMALIZE: begin
        // mode change always restarts the acquisition
        calib.mode = data[0];
        clear_sums();
      end
      REG_MIN_X:  calib.min_x  = data;
      REG_MAX_X:  calib.max_x  = data;
      REG_MIN_Y:  calib.min_y  = data;
      REG_MAX_Y:  calib.max_y  = data;
      REG_SPAN_X: calib.span_x = data[SPAN_W-1:0];
      REG_SPAN_Y: calib.span_y = data[SPAN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic touch_at(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y);
    tacs_in_t s;
    s.pen_down = 1'b1;
    s.raw_x    = x;
    s.raw_y    = y;
    send_touch(s);
  endtask

  // Pen-up carries junk coordinates; the block must ignore them.
  task automatic lift_pen();
    tacs_in_t s;
    s.pen_down = 1'b0;
    s.raw_x    = RAW_W'($urandom);
    s.raw_y    = RAW_W'($urandom);
    send_touch(s);
  endtask

  // ---------------------------------------------------------------- tests

  // Pen up straight out of reset: no event, coordinate still zero.
  task automatic test_idle_release();
    lift_pen();
  endtask

  // Single-sample mode at the reset calibration: raw extremes clip to the
  // range ends, then a press ends and a second release carries no event.
  task automatic test_clip_extremes();
    settle();
    set_reg(REG_NORMALIZE, 16'h0000);
    touch_at(16'h0000, 16'h0000);
    touch_at(16'hFFFF, 16'hFFFF);
    touch_at(16'd2048, 16'd1000);
    lift_pen();
    lift_pen();
  endtask

  // Collapsed range on x, reversed on y, then full-scale ranges with the
  // span registers at both ends.
  task automatic test_calibration_corners();
    settle();
    set_reg(REG_MIN_X, 16'd1000);
    set_reg(REG_MAX_X, 16'd1000);
    set_reg(REG_MIN_Y, 16'd3000);
    set_reg(REG_MAX_Y, 16'd100);
    touch_at(16'd500, 16'd2000);
    settle();
    set_reg(REG_MIN_X, 16'h0000);
    set_reg(REG_MAX_X, 16'hFFFF);
    set_reg(REG_MIN_Y, 16'h0000);
    set_reg(REG_MAX_Y, 16'hFFFF);
    set_reg(REG_SPAN_X, 16'hFFFF);  // upper bits beyond the span are dropped
    set_reg(REG_SPAN_Y, 16'h0000);
    touch_at(16'hFFFF, 16'h0000);
    touch_at(16'h0000, 16'hFFFF);
    lift_pen();
  endtask

  // Averaging mode with a partial sum, then a switch back to single samples:
  // the next sample alone must make the coordinate.
  task automatic test_mode_switch();
    settle();
    set_reg(REG_NORMALIZE, 16'h0001);
    touch_at(16'hFFFF, 16'hFFFF);
    touch_at(16'hFFFF, 16'hFFFF);
    touch_at(16'h8000, 16'h0001);
    settle();
    set_reg(REG_NORMALIZE, 16'hFFFE);
    touch_at(16'd40000, 16'd20000);
    lift_pen();
  endtask

  function automatic logic [RAW_W-1:0] pick_center(input logic [RAW_W-1:0] lo,
                                                   input logic [RAW_W-1:0] hi);
    if (lo < hi && $urandom_range(0, 1) == 1) return RAW_W'($urandom_range(lo, hi));
    return RAW_W'($urandom);
  endfunction

  // Sample near the stroke center; now and then a wild or rail value.
  function automatic logic [RAW_W-1:0] jitter(input logic [RAW_W-1:0] c);
    int v;
    case ($urandom_range(0, 9))
      0: return RAW_W'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? {RAW_W{1'b1}} : {RAW_W{1'b0}};
      default: begin
        v = int'(c) + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return RAW_W'(v);
      end
    endcase
  endfunction

  // Mostly sane ranges, with collapsed, reversed and full-scale ones mixed in.
  function automatic void pick_bounds(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = RAW_W'($urandom);
        hi = lo;
      end
      1: begin
        lo = RAW_W'($urandom_range(1, 65535));
        hi = RAW_W'($urandom_range(0, lo - 1));
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        lo = RAW_W'($urandom_range(0, 40000));
        hi = RAW_W'($urandom_range(lo + 1, 65535));
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_span();
    logic [SPAN_W-1:0] span;
    case ($urandom_range(0, 7))
      0: span = '0;
      1: span = '1;
      default: span = SPAN_W'($urandom);
    endcase
    return {(CFG_DATA_W - SPAN_W)'($urandom), span};
  endfunction

  // New calibration; leaving the mode alone keeps any partial sum alive.
  task automatic shuffle_calibration(input bit with_mode);
    logic [RAW_W-1:0] lo, hi;
    if (with_mode) set_reg(REG_NORMALIZE, CFG_DATA_W'($urandom));
    pick_bounds(lo, hi);
    set_reg(REG_MIN_X, lo);
    set_reg(REG_MAX_X, hi);
    pick_bounds(lo, hi);
    set_reg(REG_MIN_Y, lo);
    set_reg(REG_MAX_Y, hi);
    set_reg(REG_SPAN_X, pick_span());
    set_reg(REG_SPAN_Y, pick_span());
  endtask

  // Phases of random strokes. Most strokes are whole acquisitions followed by
  // a release; the rest stop short, run on, or skip the release.
  task automatic test_random_strokes();
    int               sent;
    int               len;
    logic [RAW_W-1:0] cx, cy;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        // full-scale calibration, widest spans, averaging on
        set_reg(REG_NORMALIZE, 16'h0001);
        set_reg(REG_MIN_X, 16'h0000);
        set_reg(REG_MAX_X, 16'hFFFF);
        set_reg(REG_MIN_Y, 16'h0000);
        set_reg(REG_MAX_Y, 16'hFFFF);
        set_reg(REG_SPAN_X, 16'h03FF);
        set_reg(REG_SPAN_Y, 16'h03FF);
      end else begin
        shuffle_calibration(ph % 3 != 0);
      end
      // some phases run without gaps or without back-pressure
      idle_on   = (ph % 4 != 2);
      stalls_on = (ph % 4 != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0)
          len = (calib.mode ? SAMPLES : 1) * $urandom_range(1, 3);
        else
          len = $urandom_range(1, 2 * SAMPLES + 3);
        cx = pick_center(calib.min_x, calib.max_x);
        cy = pick_center(calib.min_y, calib.max_y);
        repeat (len) touch_at(jitter(cx), jitter(cy));
        sent += len;
        if ($urandom_range(0, 5) != 0) begin
          lift_pen();
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_NORMALIZE;
    cfg_wdata = '0;
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_release();
    test_clip_extremes();
    test_calibration_corners();
    test_mode_switch();
    test_random_strokes();

    settle();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard: a report that never comes ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports pending", cycle_count,
             touch_reports_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
